### rtl/core/csi_pkg.sv
// shared types and constants for the cross section interpolator
// no dependencies
package csi_pkg;

	localparam logic [1:0] ACT_GRID  = 2'd0;
	localparam logic [1:0] ACT_TABLE = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam logic [2:0] REG_GRID_BASE  = 3'd0;
	localparam logic [2:0] REG_GRID_PTS   = 3'd1;
	localparam logic [2:0] REG_TABLE_BASE = 3'd2;
	localparam logic [2:0] REG_TABLE_PTS  = 3'd3;
	localparam logic [2:0] REG_THRESHOLD  = 3'd4;

	// divider request and response
	typedef struct packed {
		logic         start;
		logic [95:0]  num;
		logic [47:0]  den;
	} div_req_t;

	typedef struct packed {
		logic         done;
		logic [50:0]  quo;
	} div_rsp_t;

endpackage

### rtl/core/csi_div.sv
// restoring divider, one quotient bit per cycle, saturates at 2^50
// depends on csi_pkg
module csi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csi_pkg::div_req_t req,
	output csi_pkg::div_rsp_t rsp
);
	logic [95:0] num_q;
	logic [48:0] rem_q;
	logic [47:0] den_q;
	logic [95:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] trial;
	logic [49:0] sub;

	always_comb begin
		trial = {rem_q[47:0], num_q[95]};
		sub = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd96;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[94:0], 1'b0};
			if (!sub[49]) begin
				rem_q <= sub[48:0];
				quo_q <= {quo_q[94:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[94:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (quo_q[95:50] != '0 && !(quo_q[95:51] == '0 && quo_q[50] && quo_q[49:0] == '0))
			rsp.quo = {1'b1, 50'd0};
		else
			rsp.quo = quo_q[50:0];
	end
endmodule

### rtl/core/cross_section_interpolator.sv
// cross section interpolator top level: stores, search sequencer, interpolation
// depends on csi_pkg and csi_div
//
// channel   dir  handshake          payload
// in        in   in_valid/in_ready  action, address, write_value, query_energy
// out       out  out_valid/out_ready value_out, beyond_table
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a query runs the search on the single grid read port, a step in SRCH and SWAIT
// (12 steps for 4096 points), then the read states RD0 to RD3, a 48x48-bit product
// from 24x24-bit pieces, the divider and the output state; clamped and flat cases
// skip the divider
// stores have no reset; the block is ready right after reset
// one item at a time; the result waits in the output register until taken
module cross_section_interpolator #(
	parameter int GRID_DEPTH  = 4096,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [11:0] address,
	input  logic [47:0] write_value,
	input  logic [47:0] query_energy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] value_out,
	output logic        beyond_table,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	localparam int GW = $clog2(GRID_DEPTH);
	localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = 18;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SRCH  = 10'b0000000010,
		ST_SWAIT = 10'b0000000100,
		ST_RD0   = 10'b0000001000,
		ST_RD1   = 10'b0000010000,
		ST_RD2   = 10'b0000100000,
		ST_RD3   = 10'b0001000000,
		ST_MUL   = 10'b0010000000,
		ST_DIV   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [47:0] grid_mem [GRID_DEPTH];
	logic [47:0] table_mem [TABLE_DEPTH];
	logic [47:0] grid_rd_q, table_rd_q;
	logic [GW-1:0] grid_ra;
	logic [TW-1:0] table_ra;

	logic [11:0] grid_base_q, table_base_q, thr_q;
	logic [12:0] grid_pts_q, table_pts_q;
	logic [IW-1:0] lo_q, hi_q, mid_q, n_c, tp_c;
	logic signed [IW:0] j_q;
	logic [47:0] e_q, g0_q, g1_q, v0_q, de_q, dx_q, dv_q;
	logic neg_q;
	logic [1:0] mstep_q;
	logic [95:0] prod_q;
	logic [47:0] res_q;
	logic res_beyond_q, ovalid_q;
	logic start_q;
	csi_pkg::div_req_t dreq;
	csi_pkg::div_rsp_t drsp;
	logic [50:0] sum;

	assign n_c = (grid_pts_q < 13'd2) ? IW'(2) :
		((IW'(grid_pts_q) > IW'(GRID_DEPTH)) ? IW'(GRID_DEPTH) : IW'(grid_pts_q));
	assign tp_c = (table_pts_q < 13'd1) ? IW'(1) :
		((IW'(table_pts_q) > IW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(table_pts_q));

	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign value_out = res_q;
	assign beyond_table = res_beyond_q;

	// read address selection for the single read port of each store
	logic [IW-1:0] gidx, tidx;
	always_comb begin
		gidx = mid_q;
		tidx = IW'(j_q[IW-1:0]);
		unique case (state_q)
			ST_RD1:  gidx = lo_q + IW'(1);
			ST_RD2:  tidx = IW'(j_q[IW-1:0]) + IW'(1);
			default: ;
		endcase
		grid_ra = GW'(IW'(grid_base_q) + gidx);
		table_ra = TW'(IW'(table_base_q) + tidx);
	end

	wire wr_acc = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (wr_acc && action == csi_pkg::ACT_GRID)
			grid_mem[GW'(address)] <= write_value;
		grid_rd_q <= grid_mem[grid_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_acc && action == csi_pkg::ACT_TABLE)
			table_mem[TW'(address)] <= write_value;
		table_rd_q <= table_mem[table_ra];
	end

	assign dreq = {start_q, prod_q, de_q};

	csi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		if (neg_q)
			sum = (drsp.quo >= {3'b0, v0_q}) ? 51'd0 : {3'b0, v0_q} - drsp.quo;
		else
			sum = {3'b0, v0_q} + drsp.quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			grid_base_q <= '0;
			grid_pts_q <= 13'd2;
			table_base_q <= '0;
			table_pts_q <= 13'd1;
			thr_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid && out_ready)
				ovalid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					csi_pkg::REG_GRID_BASE:  grid_base_q <= cfg_data[11:0];
					csi_pkg::REG_GRID_PTS:   grid_pts_q <= cfg_data;
					csi_pkg::REG_TABLE_BASE: table_base_q <= cfg_data[11:0];
					csi_pkg::REG_TABLE_PTS:  table_pts_q <= cfg_data;
					csi_pkg::REG_THRESHOLD:  thr_q <= cfg_data[11:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wr_acc && action == csi_pkg::ACT_QUERY) begin
						e_q <= query_energy;
						lo_q <= '0;
						hi_q <= n_c - IW'(1);
						mid_q <= (n_c - IW'(1) + IW'(1)) >> 1;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: state_q <= ST_SWAIT;  // read of grid at mid in flight
				ST_SWAIT: begin
					logic [IW-1:0] nlo, nhi;
					nlo = lo_q;
					nhi = hi_q;
					if (lo_q < hi_q) begin
						if (grid_rd_q <= e_q) nlo = mid_q;
						else nhi = mid_q - IW'(1);
					end
					if (nlo < nhi) begin
						lo_q <= nlo;
						hi_q <= nhi;
						mid_q <= nlo + ((nhi - nlo + IW'(1)) >> 1);
						state_q <= ST_SRCH;
					end else begin
						if (nlo >= n_c - IW'(1)) nlo = n_c - IW'(2);
						lo_q <= nlo;
						mid_q <= nlo;
						j_q <= $signed({1'b0, nlo}) - $signed({{(IW-11){1'b0}}, thr_q});
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					// grid lo and table j go out now, lo+1 and j+1 follow
					if (j_q < 0) begin
						res_q <= '0;
						res_beyond_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (j_q >= $signed({1'b0, tp_c - IW'(1)})) begin
						j_q <= $signed({1'b0, tp_c - IW'(1)});
						res_beyond_q <= 1'b1;
						state_q <= ST_RD3;
					end else begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					g0_q <= grid_rd_q;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					g1_q <= grid_rd_q;
					v0_q <= table_rd_q;
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					if (res_beyond_q && j_q >= 0 && state_q == ST_RD3 && mstep_q == 2'd3) begin
						res_q <= table_rd_q;
						state_q <= ST_OUT;
					end else if (res_beyond_q) begin
						mstep_q <= 2'd3;  // wait for the last-entry read to arrive
					end else begin
						logic n;
						n = 1'b0;
						if (g1_q >= g0_q) de_q <= g1_q - g0_q;
						else begin de_q <= g0_q - g1_q; n = ~n; end
						if (e_q >= g0_q) dx_q <= e_q - g0_q;
						else begin dx_q <= g0_q - e_q; n = ~n; end
						if (table_rd_q >= v0_q) dv_q <= table_rd_q - v0_q;
						else begin dv_q <= v0_q - table_rd_q; n = ~n; end
						neg_q <= n;
						prod_q <= '0;
						mstep_q <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// 48x48 product from 24x24 pieces, accumulated by mstep
					unique case (mstep_q)
						2'd0: prod_q <= 96'(dx_q[23:0] * dv_q[23:0]);
						2'd1: prod_q <= prod_q + (96'(dx_q[47:24] * dv_q[23:0]) << 24);
						2'd2: prod_q <= prod_q + (96'(dx_q[23:0] * dv_q[47:24]) << 24);
						2'd3: prod_q <= prod_q + (96'(dx_q[47:24] * dv_q[47:24]) << 48);
					endcase
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd3) begin
						if (de_q == '0) begin
							res_q <= v0_q;
							state_q <= ST_OUT;
						end else begin
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						res_q <= (sum > {3'b0, 48'hFFFF_FFFF_FFFF}) ? 48'hFFFF_FFFF_FFFF :
							sum[47:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					mstep_q <= 2'd0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_IDLE && wr_acc && action == csi_pkg::ACT_QUERY) begin
				res_beyond_q <= 1'b0;
				mstep_q <= 2'd0;
			end
		end
	end

	// no new word while a result waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT)) else $error("stray result");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == ST_DIV) else $error("divider done outside divide");
endmodule
